>>> rtl/core/dldv_pkg.sv
`default_nettype none

package dldv_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int VAL_W    = 32;
   localparam int CMD_W    = 3;
   localparam int STS_W    = 3;

   // command codes (req_tuser)
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_FWD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_BWD  = 3'd4;

   // status codes (rsp_tuser)
   localparam logic [STS_W-1:0] STS_DONE  = 3'd0;
   localparam logic [STS_W-1:0] STS_FULL  = 3'd1;
   localparam logic [STS_W-1:0] STS_NONE  = 3'd2;
   localparam logic [STS_W-1:0] STS_ENTRY = 3'd3;
   localparam logic [STS_W-1:0] STS_EMPTY = 3'd4;

   // ring position: head plus logical offset, wrapped once
   function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] lpos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(lpos);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/deque_list_delete_by_value.sv
// Each command is accepted in S_IDLE; a status then passes through S_STAT and a read through S_READ
//   into the output register; a read gives one beat per cycle while the receiver takes each beat.
// A delete searches from the front, then closes the gap through the store; receiver stalls
//   hold status and read beats in the output register. One command in flight at a time.
// Reset (synchronous, active high) empties the list, returns to idle and clears the output valid.
`default_nettype none

module deque_list_delete_by_value
   import dldv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [VAL_W-1:0] req_tdata,   // [31:0] operand_value
   input  wire logic [CMD_W-1:0] req_tuser,   // [2:0] command
   // response channel
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [VAL_W-1:0]      rsp_tdata,   // [31:0] entry_value
   output logic [STS_W-1:0]      rsp_tuser,   // [2:0] status
   output logic                  rsp_tlast    // last_of_run
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_STAT,    // single status beat pending
      S_SEARCH,  // walk from the front looking for a match
      S_SHIFT,   // close the gap, one entry per cycle
      S_READ     // stream entries out
   } state_type;

   // Entries live in a ring: logical position 0 (front) sits at hd_ff.
   logic [VAL_W-1:0] mem [CAPACITY];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] hd_ff, hd_in;
   logic [CNT_W-1:0] lpos_ff, lpos_in;   // logical position being worked on
   logic             fwd_ff, fwd_in;
   logic [STS_W-1:0] stat_ff, stat_in;
   logic [VAL_W-1:0] op_ff, op_in;
   logic [VAL_W-1:0] mem_q_ff;           // registered read of phys(lpos)

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STS_W-1:0] rsp_user_ff, rsp_user_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [VAL_W-1:0] mem_wd;
   logic [IDX_W-1:0] mem_ra;

   logic             req_acc;
   logic             slot_free;
   logic             is_full;
   logic             rd_last;
   logic [IDX_W-1:0] hd_dec;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign is_full    = (cnt_ff == CNT_W'(CAPACITY));
   assign hd_dec     = (hd_ff == '0) ? IDX_W'(CAPACITY - 1) : hd_ff - 1'b1;
   assign rd_last    = fwd_ff ? (lpos_ff == cnt_ff - 1'b1) : (lpos_ff == '0);

   // read address follows the next logical position, so mem_q_ff holds its entry in the next cycle
   assign mem_ra = phys_addr(hd_ff, lpos_in);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      hd_in        = hd_ff;
      lpos_in      = lpos_ff;
      fwd_in       = fwd_ff;
      stat_in      = stat_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_wa       = phys_addr(hd_ff, cnt_ff);
      mem_wd       = req_tdata;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in = req_tdata;
               case (req_tuser)
                  CMD_INS_FRONT: begin
                     state_in = S_STAT;
                     if (is_full) begin
                        stat_in = STS_FULL;
                     end else begin
                        stat_in = STS_DONE;
                        mem_we  = 1'b1;
                        mem_wa  = hd_dec;
                        hd_in   = hd_dec;
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  CMD_INS_BACK: begin
                     state_in = S_STAT;
                     if (is_full) begin
                        stat_in = STS_FULL;
                     end else begin
                        stat_in = STS_DONE;
                        mem_we  = 1'b1;
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     state_in = S_SEARCH;
                     lpos_in  = '0;
                  end
                  CMD_READ_FWD, CMD_READ_BWD: begin
                     fwd_in = (req_tuser == CMD_READ_FWD);
                     if (cnt_ff == '0) begin
                        state_in = S_STAT;
                        stat_in  = STS_EMPTY;
                     end else begin
                        state_in = S_READ;
                        lpos_in  = (req_tuser == CMD_READ_FWD) ? '0 : cnt_ff - 1'b1;
                     end
                  end
                  default: begin
                     // unused codes: dropped without a result
                  end
               endcase
            end
         end

         S_STAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = stat_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (lpos_ff >= cnt_ff) begin
               stat_in  = STS_NONE;
               state_in = S_STAT;
            end else if (mem_q_ff == op_ff) begin
               state_in = S_SHIFT;
               lpos_in  = lpos_ff + 1'b1;
            end else begin
               lpos_in  = lpos_ff + 1'b1;
            end
         end

         S_SHIFT: begin
            // mem_q_ff holds entry lpos; move it down one place
            if (lpos_ff >= cnt_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               stat_in  = STS_DONE;
               state_in = S_STAT;
            end else begin
               mem_we  = 1'b1;
               mem_wa  = phys_addr(hd_ff, lpos_ff - 1'b1);
               mem_wd  = mem_q_ff;
               lpos_in = lpos_ff + 1'b1;
            end
         end

         S_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mem_q_ff;
               rsp_user_in  = STS_ENTRY;
               rsp_last_in  = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  lpos_in = fwd_ff ? lpos_ff + 1'b1 : lpos_ff - 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry storage: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         hd_ff        <= '0;
         lpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hd_ff        <= hd_in;
         lpos_ff      <= lpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fwd_ff      <= fwd_in;
      stat_ff     <= stat_in;
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (cnt_ff != '0) && (lpos_ff < cnt_ff))
      else $error("read position outside the list");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (lpos_ff != '0) && (lpos_ff <= cnt_ff))
      else $error("close-up position out of range");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_acc && !is_full &&
       (req_tuser == CMD_INS_FRONT || req_tuser == CMD_INS_BACK))
      |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("insert did not grow the list");

   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && !(req_acc && req_tuser == CMD_INS_FRONT)) |=> $stable(hd_ff))
      else $error("head moved without a front insert");
`endif

endmodule

`default_nettype wire
